>>> rtl/tempo_locked_note_pulse_generator_defines.svh
// ------------------------------------------------------------------------
// tempo locked note pulse generator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ------------------------------------------------------------------------
`ifndef TEMPO_LOCKED_NOTE_PULSE_GENERATOR_DEFINES_SVH
`define TEMPO_LOCKED_NOTE_PULSE_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define TLNPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TLNPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLNPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TLNPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/tlnpg_pkg.sv
// ------------------------------------------------------------------------
// tlnpg_pkg
// shared types, widths and constants of the note pulse generator
// ------------------------------------------------------------------------
package tlnpg_pkg;

    localparam int MAX_BLOCK_DEF      = 4096;
    localparam int EVENT_CAPACITY_DEF = 64;

    localparam int B0_W   = 48;
    localparam int NIN_W  = 13;
    localparam int TC_W   = 17;
    localparam int OFF_W  = 12;
    localparam int PITCH_W = 7;
    localparam int VEL_W  = 8;
    localparam int ID_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // shared divider geometry
    localparam int DVD_W     = 48;
    localparam int DVR_W     = 33;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd4;

    localparam logic [ID_W-1:0] FIRST_NOTE_ID = 32'd700000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_KDIV,
        ST_KSET,
        ST_REL_EVAL,
        ST_REL_CMP,
        ST_REL_DIV,
        ST_REL_EMIT,
        ST_STEP_EVAL,
        ST_STEP_CMP,
        ST_STEP_DIV,
        ST_STEP_OFF,
        ST_STEP_ON,
        ST_STEP_NEXT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic prep;
        logic kset;
        logic eval_rel;
        logic eval_step;
        logic sdiv_start;
        logic emit_rel_off;
        logic emit_step_off;
        logic emit_on;
        logic step_next;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic in_block;
        logic skip;
        logic held_valid;
        logic emit_ok;
        logic flush_ok;
    } t_stat;

    typedef struct packed {
        logic [OFF_W-1:0]   offset;
        logic               on;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
        logic [ID_W-1:0]    id;
    } t_event;

endpackage

>>> rtl/tlnpg_if.sv
// ------------------------------------------------------------------------
// tlnpg channel interfaces
// block descriptor input channel and note event output channel
// ------------------------------------------------------------------------
interface tlnpg_in_if import tlnpg_pkg::*;;
    logic             valid;
    logic             ready;
    logic [B0_W-1:0]  block_start_beat;
    logic [NIN_W-1:0] block_samples;
    logic [TC_W-1:0]  tempo_centibpm;

    modport source(output valid, block_start_beat, block_samples, tempo_centibpm,
                   input ready);
    modport sink(input valid, block_start_beat, block_samples, tempo_centibpm,
                 output ready);
endinterface

interface tlnpg_out_if import tlnpg_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OFF_W-1:0]   sample_offset;
    logic               note_on;
    logic [PITCH_W-1:0] note_pitch;
    logic [VEL_W-1:0]   note_velocity;
    logic [ID_W-1:0]    note_id;
    logic               last_event;

    modport source(output valid, sample_offset, note_on, note_pitch, note_velocity,
                   note_id, last_event, input ready);
    modport sink(input valid, sample_offset, note_on, note_pitch, note_velocity,
                 note_id, last_event, output ready);
endinterface

>>> rtl/tlnpg_div.sv
// ------------------------------------------------------------------------
// tlnpg_div
// restoring divider, one quotient bit per cycle, preloadable remainder
// ------------------------------------------------------------------------
module tlnpg_div import tlnpg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [DVR_W-1:0]     i_divisor,
    input  logic [DVR_W-1:0]     i_rem_init,
    input  logic [DIV_CNT_W-1:0] i_count,
    output logic                 o_busy,
    output logic [DVD_W-1:0]     o_quot,
    output logic [DVR_W-1:0]     o_rem
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVD_W-1:0]     r_quot;
    logic [DVR_W-1:0]     r_rem;
    logic [DVR_W-1:0]     r_dvr;
    logic [DVR_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_count;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvr  <= i_divisor;
            r_rem  <= i_rem_init;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quot <= {r_quot[DVD_W-2:0], ge};
            r_rem  <= ge ? DVR_W'(rem_sh - {1'b0, r_dvr}) : rem_sh[DVR_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> rtl/tlnpg_ctrl.sv
// ------------------------------------------------------------------------
// tlnpg_ctrl
// sequencer: block setup, pending release, step walk, event flush
// ------------------------------------------------------------------------
module tlnpg_ctrl import tlnpg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_PREP;
            ST_PREP:      n_state = ST_KDIV;
            ST_KDIV:      if (!i_stat.div_busy) n_state = ST_KSET;
            ST_KSET:      n_state = ST_REL_EVAL;
            ST_REL_EVAL:  n_state = i_stat.held_valid ? ST_REL_CMP : ST_STEP_EVAL;
            ST_REL_CMP:   n_state = i_stat.in_block ? ST_REL_DIV : ST_STEP_EVAL;
            ST_REL_DIV:   if (!i_stat.div_busy) n_state = ST_REL_EMIT;
            ST_REL_EMIT:  if (i_stat.emit_ok) n_state = ST_STEP_EVAL;
            ST_STEP_EVAL: n_state = ST_STEP_CMP;
            ST_STEP_CMP: begin
                if (!i_stat.in_block) n_state = ST_FLUSH;
                else if (i_stat.skip) n_state = ST_STEP_NEXT;
                else n_state = ST_STEP_DIV;
            end
            ST_STEP_DIV:  if (!i_stat.div_busy) n_state = ST_STEP_OFF;
            ST_STEP_OFF:  if (!i_stat.held_valid || i_stat.emit_ok) n_state = ST_STEP_ON;
            ST_STEP_ON:   if (i_stat.emit_ok) n_state = ST_STEP_NEXT;
            ST_STEP_NEXT: n_state = ST_STEP_EVAL;
            ST_FLUSH:     if (i_stat.flush_ok) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_PREP:      o_cmd.prep = 1'b1;
            ST_KSET:      o_cmd.kset = 1'b1;
            ST_REL_EVAL:  o_cmd.eval_rel = i_stat.held_valid;
            ST_REL_CMP:   o_cmd.sdiv_start = i_stat.in_block;
            ST_REL_EMIT:  o_cmd.emit_rel_off = i_stat.emit_ok;
            ST_STEP_EVAL: o_cmd.eval_step = 1'b1;
            ST_STEP_CMP:  o_cmd.sdiv_start = i_stat.in_block && !i_stat.skip;
            ST_STEP_OFF:  o_cmd.emit_step_off = i_stat.held_valid && i_stat.emit_ok;
            ST_STEP_ON:   o_cmd.emit_on = i_stat.emit_ok;
            ST_STEP_NEXT: o_cmd.step_next = 1'b1;
            ST_FLUSH:     o_cmd.flush = i_stat.flush_ok;
            default:      o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/tlnpg_dp.sv
// ------------------------------------------------------------------------
// tlnpg_dp
// datapath: settings, block geometry, note state and event staging
// ------------------------------------------------------------------------
`include "tempo_locked_note_pulse_generator_defines.svh"

module tlnpg_dp import tlnpg_pkg::*; #(
    parameter int MAX_BLOCK      = MAX_BLOCK_DEF,
    parameter int EVENT_CAPACITY = EVENT_CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [B0_W-1:0]       i_b0,
    input  logic [NIN_W-1:0]      i_n,
    input  logic [TC_W-1:0]       i_tc,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_event                o_ev,
    output logic                  o_last
);

    localparam int N_W   = $clog2(MAX_BLOCK + 1);
    localparam int QW    = $clog2(MAX_BLOCK);
    localparam int NT_W  = N_W + TC_W;
    localparam int CNT_W = $clog2(EVENT_CAPACITY + 1);

    // settings
    logic [PITCH_W-1:0] r_pitch;
    logic [10:0]        r_stepb;
    logic [8:0]         r_gate;
    logic [VEL_W-1:0]   r_vel;
    logic [17:0]        r_sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= 7'd48;
            r_stepb <= 11'd256;
            r_gate  <= 9'd128;
            r_vel   <= 8'd204;
            r_sr    <= 18'd48000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PITCH:    r_pitch <= i_cfg_data[6:0];
                CFG_STEP:     r_stepb <= i_cfg_data[10:0];
                CFG_GATE:     r_gate  <= i_cfg_data[8:0];
                CFG_VELOCITY: r_vel   <= i_cfg_data[7:0];
                CFG_RATE:     r_sr    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // block geometry, clamped at accept
    logic [B0_W-1:0] r_b0;
    logic [N_W-1:0]  r_n;
    logic [TC_W-1:0] r_tc;
    logic [17:0]     r_src;
    logic [10:0]     r_stepc;
    logic [30:0]     r_num;
    logic [NT_W-1:0] r_nt;
    logic [31:0]     n_ext, n_cl;
    logic [18:0]     sb;

    assign n_ext = 32'(i_n);
    assign n_cl  = (n_ext == 0) ? 32'd1 :
                   (n_ext > 32'(MAX_BLOCK)) ? 32'(MAX_BLOCK) : n_ext;
    assign sb    = {r_stepc, 8'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_b0    <= i_b0;
            r_n     <= n_cl[N_W-1:0];
            r_tc    <= (i_tc <= 17'd100) ? 17'd12000 : i_tc;
            r_src   <= (r_sr < 18'd8000) ? 18'd8000 :
                       (r_sr > 18'd192000) ? 18'd192000 : r_sr;
            r_stepc <= (r_stepb < 11'd13) ? 11'd13 : r_stepb;
        end
        if (i_cmd.prep) begin
            r_num <= 31'(r_src) * 31'd6000;
            r_nt  <= NT_W'(r_n) * NT_W'(r_tc);
        end
    end

    // shared divider: step index at setup, sample offset per event
    logic                 div_start, div_busy;
    logic [DVD_W-1:0]     div_dvd, div_quot;
    logic [DVR_W-1:0]     div_dvr, div_rinit, div_rem;
    logic [DIV_CNT_W-1:0] div_cnt;
    logic [52:0]          r_prod;
    logic                 r_far;

    assign div_start = i_cmd.prep || i_cmd.sdiv_start;
    assign div_dvd   = i_cmd.prep ? r_b0 : {r_prod[QW-1:0], {(DVD_W-QW){1'b0}}};
    assign div_dvr   = i_cmd.prep ? DVR_W'(sb) : {r_tc, 16'b0};
    assign div_rinit = i_cmd.prep ? '0 : DVR_W'(r_prod >> QW);
    assign div_cnt   = i_cmd.prep ? DIV_CNT_W'(DVD_W) : DIV_CNT_W'(QW);

    tlnpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvr),
        .i_rem_init (div_rinit),
        .i_count    (div_cnt),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // step walk
    logic [B0_W-1:0] r_k;
    logic [B0_W:0]   r_kbeat;
    logic [18:0]     krem;
    logic            kfrac;

    assign krem  = div_rem[18:0];
    assign kfrac = (krem != 0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.kset) begin
            // round the block start up to the next step boundary
            r_k     <= div_quot + B0_W'(kfrac);
            r_kbeat <= {1'b0, r_b0} - (B0_W+1)'(krem) + (kfrac ? (B0_W+1)'(sb) : '0);
        end else if (i_cmd.step_next) begin
            r_k     <= r_k + 1'b1;
            r_kbeat <= r_kbeat + (B0_W+1)'(sb);
        end
    end

    // note state
    logic [B0_W-1:0]    r_lfs;
    logic               r_lfv;
    logic               r_held_valid;
    logic [PITCH_W-1:0] r_held_pitch;
    logic [ID_W-1:0]    r_held_id;
    logic [49:0]        r_rel;
    logic [ID_W-1:0]    r_next_id;
    logic [ID_W-1:0]    id_on;
    logic [19:0]        gprod;

    assign id_on = r_next_id + 1'b1;
    assign gprod = 20'(r_gate) * 20'(r_stepc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfs        <= '0;
            r_lfv        <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_pitch <= '0;
            r_held_id    <= '0;
            r_rel        <= '0;
            r_next_id    <= FIRST_NOTE_ID;
        end else if (i_cmd.emit_on) begin
            r_next_id    <= id_on;
            r_held_valid <= 1'b1;
            r_held_pitch <= r_pitch;
            r_held_id    <= id_on;
            r_rel        <= {1'b0, r_kbeat} + 50'(gprod);
            r_lfs        <= r_k;
            r_lfv        <= 1'b1;
        end else if (i_cmd.emit_rel_off) begin
            r_held_valid <= 1'b0;
        end
    end

    // beat to block position: product register, then compare or divide
    logic [49:0] beat, diff;
    logic        lt;
    logic [21:0] diff_eff;
    logic [52:0] prod_c;

    assign beat     = i_cmd.eval_rel ? r_rel : {1'b0, r_kbeat};
    assign lt       = beat < {2'b0, r_b0};
    assign diff     = beat - {2'b0, r_b0};
    assign diff_eff = lt ? '0 : diff[21:0];
    assign prod_c   = {31'b0, diff_eff} * {22'b0, r_num};

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_rel || i_cmd.eval_step) begin
            r_prod <= prod_c;
            r_far  <= !lt && (|diff[49:22]);
        end
    end

    // sample offset, clamped to the block
    logic [31:0] q_ext, nm1, off_ext;

    assign q_ext   = 32'(div_quot[QW-1:0]);
    assign nm1     = 32'(r_n) - 32'd1;
    assign off_ext = (q_ext > nm1) ? nm1 : q_ext;

    // event staging: one held back so the final one can carry the last flag
    t_event           r_pend, r_out, new_ev;
    logic             r_pend_valid, r_out_valid, r_out_last;
    logic [CNT_W-1:0] r_ev_cnt;
    logic             emit_any, room, out_free;

    assign emit_any = i_cmd.emit_rel_off || i_cmd.emit_step_off || i_cmd.emit_on;
    assign room     = r_ev_cnt < CNT_W'(EVENT_CAPACITY);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        new_ev        = '0;
        new_ev.offset = off_ext[OFF_W-1:0];
        new_ev.on     = i_cmd.emit_on;
        new_ev.pitch  = i_cmd.emit_on ? r_pitch : r_held_pitch;
        new_ev.vel    = i_cmd.emit_on ? r_vel : '0;
        new_ev.id     = i_cmd.emit_on ? id_on : r_held_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ev_cnt     <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_ev_cnt <= '0;
            end
            if (emit_any && room) begin
                r_pend_valid <= 1'b1;
                r_ev_cnt     <= r_ev_cnt + 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((emit_any && room && r_pend_valid) || (i_cmd.flush && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any && room) begin
            r_pend <= new_ev;
        end
        if ((emit_any && room && r_pend_valid) || (i_cmd.flush && r_pend_valid)) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.flush;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.div_busy   = div_busy;
        o_stat.in_block   = !r_far && (64'(r_prod) < 64'({r_nt, 16'b0}));
        o_stat.skip       = r_lfv && (r_k == r_lfs);
        o_stat.held_valid = r_held_valid;
        o_stat.emit_ok    = !room || !r_pend_valid || out_free;
        o_stat.flush_ok   = !r_pend_valid || out_free;
    end

    assign o_valid = r_out_valid;
    assign o_ev    = r_out;
    assign o_last  = r_out_last;

    `TLNPG_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_ev_cnt <= CNT_W'(EVENT_CAPACITY), "event count past capacity")
    `TLNPG_ASSERT_IMP(a_pend_cnt, i_clk, i_rst_n, r_pend_valid, r_ev_cnt != 0, "staged event without count")
    `TLNPG_ASSERT_IMP(a_out_src, i_clk, i_rst_n, $rose(r_out_valid), $past(r_pend_valid), "output loaded from empty stage")

endmodule

>>> rtl/tempo_locked_note_pulse_generator.sv
// ------------------------------------------------------------------------
// tempo_locked_note_pulse_generator
// per audio block, releases the held note and fires notes on step boundaries
// ------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    block_start_beat, block_samples, tempo_centibpm
//  o_out     out  valid/ready    sample_offset, note_on, note_pitch,
//                                note_velocity, note_id, last_event
//  i_cfg_*   in   write enable   index, data (pitch, step, gate, velocity, rate)
//
//  one block at a time: setup runs the shared divider to find the first
//  step, then each fired step (one or two events) and each pending release
//  uses the same divider to compute a sample offset of QW = clog2(MAX_BLOCK)
//  bits; a step boundary that is skipped or ends the walk needs no divide
//  synchronous active-low reset; reset leaves no note held, no step fired
//  a stalled output holds the sequencer only when an event must move out
// ------------------------------------------------------------------------
module tempo_locked_note_pulse_generator import tlnpg_pkg::*; #(
    parameter int MAX_BLOCK      = MAX_BLOCK_DEF,
    parameter int EVENT_CAPACITY = EVENT_CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tlnpg_in_if.sink              i_in,
    tlnpg_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd   cmd;
    t_stat  stat;
    t_event ev;
    logic   in_ready;

    // sequencer
    tlnpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic, note state and event staging
    tlnpg_dp #(
        .MAX_BLOCK      (MAX_BLOCK),
        .EVENT_CAPACITY (EVENT_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_b0        (i_in.block_start_beat),
        .i_n         (i_in.block_samples),
        .i_tc        (i_in.tempo_centibpm),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_ev        (ev),
        .o_last      (o_out.last_event)
    );

    assign i_in.ready          = in_ready;
    assign o_out.sample_offset = ev.offset;
    assign o_out.note_on       = ev.on;
    assign o_out.note_pitch    = ev.pitch;
    assign o_out.note_velocity = ev.vel;
    assign o_out.note_id       = ev.id;

endmodule
